[rtl/core/ftr_pkg.sv]
// ----------------------------------------------------------------------------
// ftr_pkg
// Shared types and constants for the fan tach rpm and PWM duty core.
// ----------------------------------------------------------------------------
package ftr_pkg;

   localparam int NUM_FANS_DEF = 2;

   localparam int KIND_W     = 3;
   localparam int FAN_IN_W   = 2;
   localparam int SPEED_IN_W = 10;
   localparam int SPEED_W    = 9;
   localparam int DUTY_W     = 8;
   localparam int RPM_W      = 32;
   localparam int CNT_W      = 32;
   localparam int PPR_W      = 4;
   localparam int IVL_W      = 16;
   localparam int SCALE_W    = 16;

   localparam int NUM_W = CNT_W + SCALE_W;
   localparam int DEN_W = PPR_W + CNT_W;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [SCALE_W-1:0] RPM_SCALE  = 16'd60000;
   localparam logic [SPEED_W-1:0] SPEED_FULL = 9'd256;
   localparam logic [PPR_W-1:0]   PPR_RESET  = 4'd2;
   localparam logic [IVL_W-1:0]   IVL_RESET  = 16'd1000;

   localparam logic [CSR_ADDR_W-1:0] CSR_PPR = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IVL = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK    = 3'd0,
      KIND_EDGE    = 3'd1,
      KIND_SET     = 3'd2,
      KIND_RDSPEED = 3'd3,
      KIND_RDRPM   = 3'd4
   } kind_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[rtl/core/ftr_div.sv]
// ----------------------------------------------------------------------------
// ftr_div
// Shared subtract/compare unit: saturating 48/36-bit restoring divider,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ftr_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ftr_pkg::NUM_W-1:0]   dividend,
   input  logic [ftr_pkg::DEN_W-1:0]   divisor,
   output logic [ftr_pkg::RPM_W-1:0]   quotient,
   output ftr_pkg::div_status_type     status
);
   import ftr_pkg::*;

   localparam int HI_W   = NUM_W - RPM_W;
   localparam int STEP_W = $clog2(RPM_W + 1);

   typedef enum logic [1:0] {DV_IDLE, DV_CHECK, DV_STEP} dv_state_type;

   dv_state_type       state_ff;
   logic [STEP_W-1:0]  cnt_ff;
   logic               done_ff;
   logic [DEN_W-1:0]   rem_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [HI_W-1:0]    hi_ff;
   logic [RPM_W-1:0]   lo_ff;

   logic [DEN_W:0]     trial;
   logic [DEN_W+1:0]   diff;
   logic               fits;

   // one subtractor: saturation check first, then quotient bits
   always_comb begin
      if (state_ff == DV_CHECK) begin
         trial = (DEN_W+1)'(hi_ff);
      end else begin
         trial = {rem_ff, lo_ff[RPM_W-1]};
      end
      diff = {1'b0, trial} - {2'b00, den_ff};
      fits = ~diff[DEN_W+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            DV_IDLE: begin
               if (start) begin
                  hi_ff    <= dividend[NUM_W-1:RPM_W];
                  lo_ff    <= dividend[RPM_W-1:0];
                  den_ff   <= divisor;
                  state_ff <= DV_CHECK;
               end
            end
            DV_CHECK: begin
               if (fits) begin
                  lo_ff    <= '1;
                  done_ff  <= 1'b1;
                  state_ff <= DV_IDLE;
               end else begin
                  rem_ff   <= DEN_W'(hi_ff);
                  cnt_ff   <= '0;
                  state_ff <= DV_STEP;
               end
            end
            DV_STEP: begin
               rem_ff <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
               lo_ff  <= {lo_ff[RPM_W-2:0], fits};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == STEP_W'(RPM_W - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= DV_IDLE;
               end
            end
            default: state_ff <= DV_IDLE;
         endcase
      end
   end

   assign quotient    = lo_ff;
   assign status.busy = (state_ff != DV_IDLE);
   assign status.done = done_ff;

endmodule

[rtl/core/fan_tach_rpm_and_pwm_duty_core.sv]
// ----------------------------------------------------------------------------
// fan_tach_rpm_and_pwm_duty_core
// Per-fan tach pulse and millisecond counters, rpm measurement, speed/duty.
// ----------------------------------------------------------------------------
// Takes one item at a time. Ticks, tach edges, set-speed and unknown kinds
// are finished in the accepting cycle. A speed read, or an rpm read that does
// not measure, goes from the accepting cycle through ST_SEND to the result
// register. An rpm read that measures passes through the accepting state,
// ST_MUL for the pulse*60000 and pulses_per_rev*elapsed products, ST_LAUNCH
// to start the divider, then the shared subtractor in ftr_div does the 32-bit
// saturation check and then the quotient bits one at a time, ST_WAIT hands the
// quotient back and ST_SEND loads the result register; a saturated rpm skips the quotient bits.
// A result waits in the output register while the next item is taken; a new
// result waits until that register is free, which adds its wait to the item.
// ----------------------------------------------------------------------------
module fan_tach_rpm_and_pwm_duty_core #(
   parameter int NUM_FANS = ftr_pkg::NUM_FANS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [1:0] fan, [11:2] speed_in, [15:12] zero
   input  logic [ftr_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [2:0] kind
   input  logic [ftr_pkg::KIND_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] rpm, [32] rotating, [41:33] speed_out, [49:42] duty, [55:50] zero
   output logic [ftr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [ftr_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [ftr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ftr_pkg::*;

   localparam int FAN_W = (NUM_FANS > 1) ? $clog2(NUM_FANS) : 1;
   localparam int IDX_W = (FAN_W > FAN_IN_W) ? FAN_W : FAN_IN_W;
   localparam int PAD_W = RSP_DATA_W - (RPM_W + 1 + SPEED_W + DUTY_W);

   typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_LAUNCH, ST_WAIT, ST_SEND} state_type;

   state_type           state_ff;
   logic [PPR_W-1:0]    ppr_ff;
   logic [IVL_W-1:0]    ivl_ff;
   logic [CNT_W-1:0]    pulse_ff   [NUM_FANS];
   logic [CNT_W-1:0]    elapsed_ff [NUM_FANS];
   logic [RPM_W-1:0]    last_rpm_ff[NUM_FANS];
   logic [SPEED_W-1:0]  speed_ff   [NUM_FANS];
   logic [FAN_W-1:0]    fan_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [DEN_W-1:0]    den_ff;
   logic [RPM_W-1:0]    res_rpm_ff;
   logic [SPEED_W-1:0]  res_spd_ff;
   logic [DUTY_W-1:0]   res_duty_ff;
   logic                rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [FAN_IN_W-1:0]   fan_in;
   logic [SPEED_IN_W-1:0] speed_in;
   logic [IDX_W-1:0]      fan_ext;
   logic [FAN_W-1:0]      fan_idx;
   logic                  fan_ok;
   logic [SPEED_W-1:0]    clamped;
   logic [SPEED_W-1:0]    spd_sel;
   logic [SPEED_W+DUTY_W-1:0] duty_prod;
   logic [PPR_W-1:0]      ppr_eff;
   logic [IVL_W-1:0]      ivl_eff;
   logic                  due;
   logic                  accept;
   logic                  out_free;
   logic                  div_start;
   logic [RPM_W-1:0]      quotient;
   div_status_type        div_status;

   assign fan_in   = req_tdata[FAN_IN_W-1:0];
   assign speed_in = req_tdata[FAN_IN_W+SPEED_IN_W-1:FAN_IN_W];
   assign fan_ext  = IDX_W'(fan_in);
   assign fan_idx  = fan_ext[FAN_W-1:0];
   assign fan_ok   = ({1'b0, fan_ext} < (IDX_W+1)'(NUM_FANS));

   assign ppr_eff = (ppr_ff == '0) ? PPR_W'(1) : ppr_ff;
   assign ivl_eff = (ivl_ff == '0) ? IVL_W'(1) : ivl_ff;

   always_comb begin
      if (speed_in[SPEED_IN_W-1]) begin
         clamped = '0;
      end else if (speed_in[SPEED_W-1:0] > SPEED_FULL) begin
         clamped = SPEED_FULL;
      end else begin
         clamped = speed_in[SPEED_W-1:0];
      end
   end

   // duty = floor(255 * s / 256)
   assign spd_sel   = fan_ok ? speed_ff[fan_idx] : '0;
   assign duty_prod = {spd_sel, {DUTY_W{1'b0}}} - (SPEED_W+DUTY_W)'(spd_sel);

   assign due       = fan_ok && (elapsed_ff[fan_idx] >= CNT_W'(ivl_eff));
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign div_start  = (state_ff == ST_LAUNCH);

   ftr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (den_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ppr_ff <= PPR_RESET;
         ivl_ff <= IVL_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_PPR: ppr_ff <= csr_wdata[PPR_W-1:0];
            CSR_IVL: ivl_ff <= csr_wdata[IVL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fan_ff       <= '0;
         for (int i = 0; i < NUM_FANS; i++) begin
            pulse_ff[i]    <= '0;
            elapsed_ff[i]  <= '0;
            last_rpm_ff[i] <= '0;
            speed_ff[i]    <= '0;
         end
      end else begin
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (kind_type'(req_tuser))
                     KIND_TICK: begin
                        for (int i = 0; i < NUM_FANS; i++) begin
                           if (elapsed_ff[i] != '1) begin
                              elapsed_ff[i] <= elapsed_ff[i] + 1'b1;
                           end
                        end
                     end
                     KIND_EDGE: begin
                        if (fan_ok && pulse_ff[fan_idx] != '1) begin
                           pulse_ff[fan_idx] <= pulse_ff[fan_idx] + 1'b1;
                        end
                     end
                     KIND_SET: begin
                        if (fan_ok) begin
                           speed_ff[fan_idx] <= clamped;
                        end
                     end
                     KIND_RDSPEED: begin
                        res_rpm_ff  <= '0;
                        res_spd_ff  <= spd_sel;
                        res_duty_ff <= duty_prod[SPEED_W+DUTY_W-2:SPEED_W-1];
                        state_ff    <= ST_SEND;
                     end
                     KIND_RDRPM: begin
                        res_spd_ff  <= '0;
                        res_duty_ff <= '0;
                        fan_ff      <= fan_idx;
                        if (due) begin
                           state_ff <= ST_MUL;
                        end else begin
                           res_rpm_ff <= fan_ok ? last_rpm_ff[fan_idx] : '0;
                           state_ff   <= ST_SEND;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_MUL: begin
               num_ff   <= NUM_W'(pulse_ff[fan_ff]) * NUM_W'(RPM_SCALE);
               den_ff   <= DEN_W'(ppr_eff) * DEN_W'(elapsed_ff[fan_ff]);
               state_ff <= ST_LAUNCH;
            end
            ST_LAUNCH: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (div_status.done) begin
                  last_rpm_ff[fan_ff] <= quotient;
                  pulse_ff[fan_ff]    <= '0;
                  elapsed_ff[fan_ff]  <= '0;
                  res_rpm_ff          <= quotient;
                  state_ff            <= ST_SEND;
               end
            end
            ST_SEND: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {{PAD_W{1'b0}}, res_duty_ff, res_spd_ff,
                                   (res_rpm_ff != '0), res_rpm_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
